// ===== design/bhte_pkg.sv =====
// bhte_pkg: shared constants, codes and types of the bucketed hash table engine
// no dependencies; used by every module of the block

package bhte_pkg;

  // table geometry (bucket count must be a power of two)
  localparam int BUCKET_COUNT = 256;
  localparam int BUCKET_SLOTS = 8;
  localparam int BKT_W        = $clog2(BUCKET_COUNT);
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS);
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 64;
  localparam int CNT_W        = 11;

  // stream payload layout
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  // one bucket row as stored in the row memory
  typedef struct packed {
    logic [SLOT_W-1:0]                  fill;
    logic [BUCKET_SLOTS-1:0][KEY_W-1:0] keys;
    logic [BUCKET_SLOTS-1:0][VAL_W-1:0] vals;
  } row_t;

  // outcome of the parallel key compare
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_t;

  // outcome of the row update
  typedef struct packed {
    logic             wr_en;
    logic             inc;
    logic             dec;
    logic [1:0]       status;
    logic [VAL_W-1:0] found;
  } upd_t;

endpackage

// ===== design/bhte_row_mem.sv =====
// bhte_row_mem: one-port-read, one-port-write row memory, one row per bucket
// depends on bhte_pkg; rows never written read back with a zero fill count

module bhte_row_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [bhte_pkg::BKT_W-1:0] rd_addr,
  output bhte_pkg::row_t            rd_row,
  input  logic                      wr_en,
  input  logic [bhte_pkg::BKT_W-1:0] wr_addr,
  input  bhte_pkg::row_t            wr_row
);

  bhte_pkg::row_t                        mem [bhte_pkg::BUCKET_COUNT];
  bhte_pkg::row_t                        rd_q_r;
  logic                                  rd_vld_r;
  logic [bhte_pkg::BUCKET_COUNT-1:0]     vld_r;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // per-row written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // an unwritten row holds no entries
  always_comb begin
    rd_row = rd_q_r;
    if (!rd_vld_r) begin
      rd_row.fill = '0;
    end
  end

endmodule

// ===== design/bhte_match.sv =====
// bhte_match: compares a key against every live slot of a row in parallel
// depends on bhte_pkg; returns the lowest matching slot

module bhte_match (
  input  logic [bhte_pkg::KEY_W-1:0] key,
  input  bhte_pkg::row_t             row,
  output bhte_pkg::match_t           result
);

  localparam int SW = bhte_pkg::SLOT_W;

  logic [bhte_pkg::BUCKET_SLOTS-1:0] hit_vec;

  // per-slot compare, limited to filled slots
  always_comb begin
    for (int i = 0; i < bhte_pkg::BUCKET_SLOTS; i++) begin
      hit_vec[i] = (SW'(i) < row.fill) && (row.keys[i] == key);
    end
  end

  // lowest slot wins
  always_comb begin
    result.hit  = |hit_vec;
    result.slot = '0;
    for (int i = bhte_pkg::BUCKET_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        result.slot = SW'(i);
      end
    end
  end

endmodule

// ===== design/bhte_update.sv =====
// bhte_update: builds the written-back row and the result of one operation
// depends on bhte_pkg; append for insert, shift down for remove

module bhte_update (
  input  logic [1:0]                 op,
  input  logic [bhte_pkg::KEY_W-1:0] key,
  input  logic [bhte_pkg::VAL_W-1:0] value,
  input  bhte_pkg::row_t             row,
  input  bhte_pkg::match_t           match,
  output bhte_pkg::row_t             new_row,
  output bhte_pkg::upd_t             upd
);

  localparam int SW = bhte_pkg::SLOT_W;

  logic full;
  logic ins_ok;
  logic rm_ok;

  // decode the operation outcome
  always_comb begin
    full   = (row.fill == SW'(bhte_pkg::BUCKET_SLOTS - 1));
    ins_ok = (op == bhte_pkg::OP_INSERT) && !match.hit && !full;
    rm_ok  = (op == bhte_pkg::OP_REMOVE) && match.hit;

    upd.wr_en  = ins_ok || rm_ok;
    upd.inc    = ins_ok;
    upd.dec    = rm_ok;
    upd.found  = '0;
    upd.status = bhte_pkg::ST_MISS;
    if (op == bhte_pkg::OP_INSERT) begin
      if (match.hit) begin
        upd.status = bhte_pkg::ST_DUP;
      end else if (full) begin
        upd.status = bhte_pkg::ST_FULL;
      end else begin
        upd.status = bhte_pkg::ST_OK;
      end
    end else if (match.hit) begin
      upd.status = bhte_pkg::ST_OK;
      upd.found  = row.vals[match.slot];
    end
  end

  // new row contents: append or close the gap
  always_comb begin
    new_row = row;
    if (ins_ok) begin
      new_row.keys[row.fill] = key;
      new_row.vals[row.fill] = value;
      new_row.fill           = row.fill + SW'(1);
    end else if (rm_ok) begin
      for (int j = 0; j < bhte_pkg::BUCKET_SLOTS - 1; j++) begin
        if (SW'(j) >= match.slot) begin
          new_row.keys[j] = row.keys[j + 1];
          new_row.vals[j] = row.vals[j + 1];
        end
      end
      new_row.fill = row.fill - SW'(1);
    end
  end

endmodule

// ===== design/bucketed_hash_table_engine.sv =====
// bucketed_hash_table_engine: top level with sequencer and result register
// depends on bhte_pkg, bhte_row_mem, bhte_match and bhte_update

// Key/value table of 64-bit keys and values in 256 buckets of up to 7 entries,
// the bucket taken from the low 8 key bits. Each bucket is one row of a single
// memory with a registered read. An operation steps through S_IDLE (row read
// issued on acceptance), S_CMP (parallel compare of all slots) and S_WR
// (write-back of the appended or shifted row together with loading the result
// register). One operation is in flight at a time, so the read of the next
// operation always sees the row already written back. A finished result waits
// in the output register while the next operation is accepted; the write-back
// waits only while that register still holds an untaken result. No clearing
// pass is needed after reset: per-row flags mark rows never written as empty.

module bucketed_hash_table_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] opcode, [65:2] key, [129:66] value, [135:130] zero
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [65:2] found_value, [76:66] entry_count, [79:77] zero
  output logic [79:0]  out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_WR   = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [1:0]                      op_r;
  logic [bhte_pkg::KEY_W-1:0]      key_r;
  logic [bhte_pkg::VAL_W-1:0]      val_r;
  bhte_pkg::match_t                match_r;
  bhte_pkg::match_t                match_c;
  bhte_pkg::row_t                  rd_row;
  bhte_pkg::row_t                  new_row;
  bhte_pkg::upd_t                  upd;
  logic [bhte_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            out_vld_r;
  logic [bhte_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            accept;
  logic                            load;
  logic                            mem_we;

  // handshake
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign load       = (state_r == S_WR) && (!out_vld_r || out_tready);
  assign mem_we     = load && upd.wr_en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // row memory
  bhte_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_tdata[2 +: bhte_pkg::BKT_W]),
    .rd_row  (rd_row),
    .wr_en   (mem_we),
    .wr_addr (key_r[bhte_pkg::BKT_W-1:0]),
    .wr_row  (new_row)
  );

  // slot compare
  bhte_match u_match (
    .key    (key_r),
    .row    (rd_row),
    .result (match_c)
  );

  // row modify
  bhte_update u_update (
    .op      (op_r),
    .key     (key_r),
    .value   (val_r),
    .row     (rd_row),
    .match   (match_r),
    .new_row (new_row),
    .upd     (upd)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_WR;
      S_WR:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // entry count after this operation
  always_comb begin
    count_nxt = count_r;
    if (upd.inc) begin
      count_nxt = count_r + bhte_pkg::CNT_W'(1);
    end else if (upd.dec) begin
      count_nxt = count_r - bhte_pkg::CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        count_r   <= count_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tdata[1:0];
      key_r <= in_tdata[65:2];
      val_r <= in_tdata[129:66];
    end
    if (state_r == S_CMP) begin
      match_r <= match_c;
    end
    if (load) begin
      out_data_r <= {3'b000, count_nxt, upd.found, upd.status};
    end
  end

  // memory is written only on the cycle a result is produced
  a_we_in_wr : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WR) && (state_nxt == S_IDLE))
    else $error("row write outside write-back");

  // entry count moves only with a produced result
  a_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(count_r))
    else $error("entry count changed without a result");

  // a matched lookup, remove or unused-code operation reports success
  a_lookup_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (load && (op_r != bhte_pkg::OP_INSERT) && match_r.hit) |=>
      (out_tdata[1:0] == bhte_pkg::ST_OK))
    else $error("matched lookup did not report success");

  // a failed operation leaves memory and count untouched
  a_fail_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (load && (upd.status != bhte_pkg::ST_OK)) |-> !mem_we && (count_nxt == count_r))
    else $error("failed operation modified the table");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for bucketed_hash_table_engine
// depends on bhte_pkg and the bucketed_hash_table_engine design files

module tb;

  localparam int N_RANDOM    = 1800;
  localparam int QUIET_FROM  = 1500;
  localparam int POOL_SIZE   = 48;
  localparam int POOL_BKTS   = 6;
  localparam int DRAIN_WAIT  = 20;
  localparam int LONG_HOLD   = 300;
  localparam int KEY_HI_W    = bhte_pkg::KEY_W - bhte_pkg::BKT_W;

  // unused opcode, handled as a lookup
  localparam logic [1:0] OP_SPARE = 2'd3;

  // one predicted reply of the table
  typedef struct {
    logic [1:0]                 status;
    logic [bhte_pkg::VAL_W-1:0] found;
    logic [bhte_pkg::CNT_W-1:0] count;
  } reply_t;

  // table model plus queue of predicted replies
  class table_scoreboard;
    logic [bhte_pkg::KEY_W-1:0] tbl_key [bhte_pkg::BUCKET_COUNT][bhte_pkg::BUCKET_SLOTS];
    logic [bhte_pkg::VAL_W-1:0] tbl_val [bhte_pkg::BUCKET_COUNT][bhte_pkg::BUCKET_SLOTS];
    int                         tbl_fill [bhte_pkg::BUCKET_COUNT];
    logic [bhte_pkg::CNT_W-1:0] tbl_total;
    reply_t                     pending_replies [$];
    int                         n_requests;
    int                         n_replies;
    int                         n_errors;
    int                         n_status [4];

    function new();
      foreach (tbl_fill[b]) tbl_fill[b] = 0;
      tbl_total = '0;
      n_requests = 0;
      n_replies = 0;
      n_errors = 0;
      foreach (n_status[s]) n_status[s] = 0;
    endfunction

    // apply one accepted request to the model and queue its reply
    function void note_request(logic [1:0] op, logic [bhte_pkg::KEY_W-1:0] key,
                               logic [bhte_pkg::VAL_W-1:0] val);
      int     bkt;
      int     fill;
      int     hit;
      reply_t r;
      bkt  = int'(key[bhte_pkg::BKT_W-1:0]);
      fill = tbl_fill[bkt];
      hit  = -1;
      // lowest matching slot wins
      for (int i = 0; i < fill; i++)
        if (hit < 0 && tbl_key[bkt][i] == key) hit = i;
      r.status = bhte_pkg::ST_MISS;
      r.found  = '0;
      case (op)
        bhte_pkg::OP_INSERT: begin
          if (hit >= 0) begin
            r.status = bhte_pkg::ST_DUP;
          end else if (fill >= bhte_pkg::BUCKET_SLOTS - 1) begin
            r.status = bhte_pkg::ST_FULL;
          end else begin
            tbl_key[bkt][fill] = key;
            tbl_val[bkt][fill] = val;
            tbl_fill[bkt] = fill + 1;
            tbl_total = tbl_total + 1'b1;
            r.status = bhte_pkg::ST_OK;
          end
        end
        bhte_pkg::OP_REMOVE: begin
          if (hit >= 0) begin
            r.found = tbl_val[bkt][hit];
            // close the gap left by the removed entry
            for (int j = hit; j + 1 < fill; j++) begin
              tbl_key[bkt][j] = tbl_key[bkt][j+1];
              tbl_val[bkt][j] = tbl_val[bkt][j+1];
            end
            tbl_fill[bkt] = fill - 1;
            tbl_total = tbl_total - 1'b1;
            r.status = bhte_pkg::ST_OK;
          end
        end
        default: begin
          // lookup, and the unused code behaves the same
          if (hit >= 0) begin
            r.found  = tbl_val[bkt][hit];
            r.status = bhte_pkg::ST_OK;
          end
        end
      endcase
      r.count = tbl_total;
      pending_replies.push_back(r);
      n_requests++;
    endfunction

    // compare one accepted reply against the oldest prediction
    function void check_reply(logic [bhte_pkg::OUT_TDATA_W-1:0] data);
      reply_t                     e;
      logic [1:0]                 st;
      logic [bhte_pkg::VAL_W-1:0] fv;
      logic [bhte_pkg::CNT_W-1:0] cnt;
      st  = data[1:0];
      fv  = data[65:2];
      cnt = data[76:66];
      n_replies++;
      if (pending_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected reply status=%0d value=%h count=%0d",
                   st, fv, cnt);
        return;
      end
      e = pending_replies.pop_front();
      n_status[e.status]++;
      if (st !== e.status || fv !== e.found || cnt !== e.count) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"ERROR: reply %0d exp status=%0d value=%h count=%0d,",
                    " got status=%0d value=%h count=%0d"},
                   n_replies, e.status, e.found, e.count, st, fv, cnt);
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [bhte_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [bhte_pkg::OUT_TDATA_W-1:0] out_tdata;

  table_scoreboard sb = new();

  bit quiet;
  int rx_hold_req;
  logic [bhte_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  bucketed_hash_table_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // known input values from time zero
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    quiet      = 1'b0;
    rx_hold_req = 0;
  end

  // result sink: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (quiet) begin
        out_tready = 1'b1;
      end else if (burst > 0) begin
        out_tready = 1'b0;
        burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(1, 11) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata);
  end

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [1:0] op, logic [bhte_pkg::KEY_W-1:0] key,
                              logic [bhte_pkg::VAL_W-1:0] val);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {6'd0, val, key, op};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, key, val);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // a handful of buckets, several keys each, so buckets fill and overflow
  task automatic refill_pool();
    logic [bhte_pkg::BKT_W-1:0] bkts [POOL_BKTS];
    foreach (bkts[i]) bkts[i] = bhte_pkg::BKT_W'($urandom);
    foreach (key_pool[i])
      key_pool[i] = {KEY_HI_W'({$urandom, $urandom}), bkts[i % POOL_BKTS]};
  endtask

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return bhte_pkg::OP_LOOKUP;
    if (r < 70) return bhte_pkg::OP_INSERT;
    if (r < 95) return bhte_pkg::OP_REMOVE;
    return OP_SPARE;
  endfunction

  // main stimulus
  initial begin : stimulus
    logic [bhte_pkg::KEY_W-1:0] ones;
    logic [bhte_pkg::KEY_W-1:0] k;
    ones = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, zero value, duplicate, full bucket, shift on remove
    send_request(bhte_pkg::OP_LOOKUP, 64'd0, 64'd0);
    send_request(bhte_pkg::OP_REMOVE, 64'd0, 64'd0);
    send_request(bhte_pkg::OP_INSERT, 64'd0, 64'd0);
    send_request(bhte_pkg::OP_LOOKUP, 64'd0, ones);
    send_request(bhte_pkg::OP_INSERT, 64'd0, ones);
    for (int i = 1; i <= 6; i++)
      send_request(bhte_pkg::OP_INSERT, 64'(i) << bhte_pkg::BKT_W,
                   {32'hA5A5_0000 + i, 32'h5A5A_FFFF - i});
    send_request(bhte_pkg::OP_INSERT, 64'd7 << bhte_pkg::BKT_W, ones);
    send_request(bhte_pkg::OP_INSERT, 64'd3 << bhte_pkg::BKT_W, ones);
    send_request(bhte_pkg::OP_REMOVE, 64'd2 << bhte_pkg::BKT_W, 64'd0);
    send_request(bhte_pkg::OP_LOOKUP, 64'd6 << bhte_pkg::BKT_W, 64'd0);
    send_request(OP_SPARE, 64'd4 << bhte_pkg::BKT_W, 64'd0);
    send_request(bhte_pkg::OP_INSERT, ones, ones);
    send_request(bhte_pkg::OP_LOOKUP, ones, 64'd0);
    send_request(bhte_pkg::OP_REMOVE, ones, 64'd0);
    send_request(bhte_pkg::OP_LOOKUP, ones, 64'd0);
    send_request(bhte_pkg::OP_REMOVE, 64'd0, 64'd0);
    send_request(bhte_pkg::OP_LOOKUP, 64'd1 << bhte_pkg::BKT_W, 64'd0);
    // vacated slots get rewritten and read back
    send_request(bhte_pkg::OP_INSERT, 64'd7 << bhte_pkg::BKT_W, 64'h0123_4567_89AB_CDEF);
    send_request(bhte_pkg::OP_LOOKUP, 64'd7 << bhte_pkg::BKT_W, 64'd0);
    send_request(bhte_pkg::OP_REMOVE, 64'd1 << bhte_pkg::BKT_W, 64'd0);

    // random: mostly keys from a small pool, some fully random keys
    refill_pool();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > 0 && n % 250 == 0) refill_pool();
      if (n == 600) begin
        drop_valid();
        wait_drained();
      end
      if (n == 900) rx_hold_req = LONG_HOLD;
      if (n == QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(pick_op(), k, {$urandom, $urandom});
    end
    drop_valid();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("summary: %0d requests, %0d replies (ok %0d, miss %0d, full %0d, dup %0d)",
             sb.n_requests, sb.n_replies, sb.n_status[bhte_pkg::ST_OK],
             sb.n_status[bhte_pkg::ST_MISS], sb.n_status[bhte_pkg::ST_FULL],
             sb.n_status[bhte_pkg::ST_DUP]);
    $display("summary: %0d mismatches, %0d replies still expected",
             sb.n_errors, sb.outstanding());
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("bucketed_hash_table_engine test passed");
    end else begin
      $display("bucketed_hash_table_engine test failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("timeout: %0d replies still expected", sb.outstanding());
    $display("bucketed_hash_table_engine test failed");
    $finish;
  end

endmodule
